// ===== sv/stt_pkg.sv =====
package stt_pkg;

   localparam int POSITION_BITS_DEFAULT = 16;
   localparam int QUEUE_DEPTH = 4;

   localparam logic [15:0] COUNT_MAX = 16'hffff;

   // token kinds
   localparam logic [4:0] KIND_END     = 5'd0;
   localparam logic [4:0] KIND_KW_BASE = 5'd1;
   localparam logic [4:0] KIND_IDENT   = 5'd9;
   localparam logic [4:0] KIND_NUMBER  = 5'd10;
   localparam logic [4:0] KIND_STRING  = 5'd11;
   localparam logic [4:0] KIND_PLUS    = 5'd12;
   localparam logic [4:0] KIND_MINUS   = 5'd13;
   localparam logic [4:0] KIND_STAR    = 5'd14;
   localparam logic [4:0] KIND_SLASH   = 5'd15;
   localparam logic [4:0] KIND_PERCENT = 5'd16;
   localparam logic [4:0] KIND_LT      = 5'd17;
   localparam logic [4:0] KIND_LTE     = 5'd18;
   localparam logic [4:0] KIND_GT      = 5'd19;
   localparam logic [4:0] KIND_GTE     = 5'd20;
   localparam logic [4:0] KIND_EQ      = 5'd21;
   localparam logic [4:0] KIND_NEQ     = 5'd22;
   localparam logic [4:0] KIND_ASSIGN  = 5'd23;
   localparam logic [4:0] KIND_LBRACE  = 5'd24;
   localparam logic [4:0] KIND_RBRACE  = 5'd25;
   localparam logic [4:0] KIND_LPAREN  = 5'd26;
   localparam logic [4:0] KIND_RPAREN  = 5'd27;
   localparam logic [4:0] KIND_DOTDOT  = 5'd28;
   localparam logic [4:0] KIND_ERROR   = 5'd29;

   // error codes
   localparam logic [1:0] ERR_NONE    = 2'd0;
   localparam logic [1:0] ERR_BANG    = 2'd1;
   localparam logic [1:0] ERR_DOT     = 2'd2;
   localparam logic [1:0] ERR_UNKNOWN = 2'd3;

   // keyword text, first byte in the low bits, with lengths
   localparam logic [39:0] KW_TEXT [8] = '{
      40'h00_7473_656e,
      40'h00_0074_656c,
      40'h00_0000_6669,
      40'h00_6573_6c65,
      40'h65_6c69_6877,
      40'h00_0072_6f66,
      40'h00_0000_6e69,
      40'h74_6e69_7270
   };
   localparam logic [2:0] KW_LEN [8] = '{
      3'd4, 3'd3, 3'd2, 3'd4, 3'd5, 3'd3, 3'd2, 3'd5
   };

   typedef struct packed {
      logic [7:0] source_byte;
      logic       end_of_source;
   } stt_item_type;

   typedef struct packed {
      logic [4:0]  token_kind;
      logic [15:0] text_start;
      logic [15:0] text_length;
      logic [15:0] line_number_out;
      logic [1:0]  error_kind;
      logic [7:0]  error_byte;
      logic        last_result;
   } stt_result_type;

   // results of one accepted transaction, in order
   typedef struct packed {
      logic [1:0]     count;
      stt_result_type slot1;
      stt_result_type slot0;
   } stt_push_type;

endpackage

// ===== sv/stt_req_if.sv =====
interface stt_req_if import stt_pkg::*; ();
   logic         valid;
   logic         ready;
   stt_item_type data;

   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface

// ===== sv/stt_rsp_if.sv =====
interface stt_rsp_if import stt_pkg::*; ();
   logic           valid;
   logic           ready;
   stt_result_type data;

   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface

// ===== sv/stt_lexer.sv =====
module stt_lexer import stt_pkg::*; #(
   parameter int POSITION_BITS = POSITION_BITS_DEFAULT
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         accept,
   input  stt_item_type item,
   output stt_push_type push
);

   typedef enum logic [3:0] {
      PH_START = 4'd0,
      PH_IDENT = 4'd1,
      PH_NUM   = 4'd2,
      PH_STR   = 4'd3,
      PH_EQ    = 4'd4,
      PH_BANG  = 4'd5,
      PH_LT    = 4'd6,
      PH_GT    = 4'd7,
      PH_DOT   = 4'd8,
      PH_ERR   = 4'd9
   } phase_type;

   localparam logic [POSITION_BITS-1:0] POS_MAX = '1;

   phase_type                phase_ff, phase_in;
   logic [POSITION_BITS-1:0] pos_ff, pos_in;
   logic [15:0]              line_ff, line_in;
   logic [POSITION_BITS-1:0] tok_start_ff, tok_start_in;
   logic [15:0]              tok_len_ff, tok_len_in;
   logic [39:0]              window_ff, window_in;

   function automatic logic is_digit(logic [7:0] b);
      return b >= "0" && b <= "9";
   endfunction

   function automatic logic is_alpha(logic [7:0] b);
      return (b >= "a" && b <= "z") || (b >= "A" && b <= "Z");
   endfunction

   function automatic logic is_space(logic [7:0] b);
      return b == " " || (b >= 8'd9 && b <= 8'd13);
   endfunction

   function automatic logic [15:0] sat16(logic [15:0] v);
      return (v == COUNT_MAX) ? v : v + 16'd1;
   endfunction

   function automatic logic [4:0] ident_kind(logic [39:0] w, logic [15:0] len);
      logic [4:0] k;
      k = KIND_IDENT;
      for (int i = 7; i >= 0; i--) begin
         if (len == 16'(KW_LEN[i]) && w == KW_TEXT[i]) k = KIND_KW_BASE + 5'(i);
      end
      return k;
   endfunction

   function automatic stt_result_type mk(logic [4:0] k, logic [15:0] st, logic [15:0] ln,
                                         logic [1:0] ek, logic [7:0] eb, logic [15:0] line);
      stt_result_type r;
      r.token_kind      = k;
      r.text_start      = st;
      r.text_length     = ln;
      r.line_number_out = line;
      r.error_kind      = ek;
      r.error_byte      = eb;
      r.last_result     = 1'b0;
      return r;
   endfunction

   logic [7:0]     b;
   logic [15:0]    p16, s16;
   logic           do_start;
   logic [1:0]     n;
   stt_result_type res [2];

   assign b   = item.source_byte;
   assign p16 = 16'(pos_ff);
   assign s16 = 16'(tok_start_ff);

   always_comb begin
      phase_in     = phase_ff;
      pos_in       = pos_ff;
      line_in      = line_ff;
      tok_start_in = tok_start_ff;
      tok_len_in   = tok_len_ff;
      window_in    = window_ff;
      do_start     = 1'b0;
      n            = 2'd0;
      res[0]       = '0;
      res[1]       = '0;

      if (accept && item.end_of_source) begin
         // flush the open token, then the end token
         unique case (phase_ff)
            PH_IDENT: begin
               res[0] = mk(ident_kind(window_ff, tok_len_ff), s16, tok_len_ff,
                           ERR_NONE, 8'd0, line_ff);
               n = 2'd1;
            end
            PH_NUM: begin
               res[0] = mk(KIND_NUMBER, s16, tok_len_ff, ERR_NONE, 8'd0, line_ff);
               n = 2'd1;
            end
            PH_STR: begin
               res[0] = mk(KIND_STRING, s16, tok_len_ff, ERR_NONE, 8'd0, line_ff);
               n = 2'd1;
            end
            PH_EQ: begin
               res[0] = mk(KIND_ASSIGN, s16, 16'd1, ERR_NONE, 8'd0, line_ff);
               n = 2'd1;
            end
            PH_LT: begin
               res[0] = mk(KIND_LT, s16, 16'd1, ERR_NONE, 8'd0, line_ff);
               n = 2'd1;
            end
            PH_GT: begin
               res[0] = mk(KIND_GT, s16, 16'd1, ERR_NONE, 8'd0, line_ff);
               n = 2'd1;
            end
            PH_BANG: begin
               res[0] = mk(KIND_ERROR, s16, 16'd1, ERR_BANG, "!", line_ff);
               n = 2'd1;
            end
            PH_DOT: begin
               res[0] = mk(KIND_ERROR, s16, 16'd1, ERR_DOT, ".", line_ff);
               n = 2'd1;
            end
            default: ;
         endcase
         res[n[0]] = mk(KIND_END, p16, 16'd0, ERR_NONE, 8'd0, line_ff);
         n = n + 2'd1;
         phase_in     = PH_START;
         pos_in       = '0;
         line_in      = 16'd1;
         tok_start_in = '0;
         tok_len_in   = 16'd0;
         window_in    = '0;
      end else if (accept) begin
         unique case (phase_ff)
            PH_IDENT: begin
               if (is_alpha(b) || is_digit(b) || b == "_") begin
                  unique case (tok_len_ff)
                     16'd1: window_in[15:8]  = window_ff[15:8] | b;
                     16'd2: window_in[23:16] = window_ff[23:16] | b;
                     16'd3: window_in[31:24] = window_ff[31:24] | b;
                     16'd4: window_in[39:32] = window_ff[39:32] | b;
                     default: ;
                  endcase
                  tok_len_in = sat16(tok_len_ff);
               end else begin
                  res[0] = mk(ident_kind(window_ff, tok_len_ff), s16, tok_len_ff,
                              ERR_NONE, 8'd0, line_ff);
                  n = 2'd1;
                  do_start = 1'b1;
               end
            end
            PH_NUM: begin
               if (is_digit(b)) begin
                  tok_len_in = sat16(tok_len_ff);
               end else begin
                  res[0] = mk(KIND_NUMBER, s16, tok_len_ff, ERR_NONE, 8'd0, line_ff);
                  n = 2'd1;
                  do_start = 1'b1;
               end
            end
            PH_STR: begin
               if (b == "\"") begin
                  res[0] = mk(KIND_STRING, s16, tok_len_ff, ERR_NONE, 8'd0, line_ff);
                  n = 2'd1;
                  phase_in = PH_START;
               end else begin
                  tok_len_in = sat16(tok_len_ff);
               end
            end
            PH_EQ, PH_LT, PH_GT: begin
               if (b == "=") begin
                  res[0] = mk((phase_ff == PH_EQ) ? KIND_EQ :
                              (phase_ff == PH_LT) ? KIND_LTE : KIND_GTE,
                              s16, 16'd2, ERR_NONE, 8'd0, line_ff);
                  phase_in = PH_START;
               end else begin
                  res[0] = mk((phase_ff == PH_EQ) ? KIND_ASSIGN :
                              (phase_ff == PH_LT) ? KIND_LT : KIND_GT,
                              s16, 16'd1, ERR_NONE, 8'd0, line_ff);
                  do_start = 1'b1;
               end
               n = 2'd1;
            end
            PH_BANG: begin
               if (b == "=") begin
                  res[0] = mk(KIND_NEQ, s16, 16'd2, ERR_NONE, 8'd0, line_ff);
                  phase_in = PH_START;
               end else begin
                  res[0] = mk(KIND_ERROR, s16, 16'd1, ERR_BANG, "!", line_ff);
                  phase_in = PH_ERR;
               end
               n = 2'd1;
            end
            PH_DOT: begin
               if (b == ".") begin
                  res[0] = mk(KIND_DOTDOT, s16, 16'd2, ERR_NONE, 8'd0, line_ff);
                  phase_in = PH_START;
               end else begin
                  res[0] = mk(KIND_ERROR, s16, 16'd1, ERR_DOT, ".", line_ff);
                  phase_in = PH_ERR;
               end
               n = 2'd1;
            end
            PH_ERR: ;
            default: do_start = 1'b1;
         endcase

         // byte that opens a new token after the previous one closed
         if (do_start) begin
            phase_in = PH_START;
            if (is_space(b)) begin
               if (b == 8'h0a) line_in = sat16(line_ff);
            end else if (is_digit(b)) begin
               phase_in     = PH_NUM;
               tok_start_in = pos_ff;
               tok_len_in   = 16'd1;
            end else if (is_alpha(b)) begin
               phase_in     = PH_IDENT;
               tok_start_in = pos_ff;
               tok_len_in   = 16'd1;
               window_in    = 40'(b);
            end else if (b == "\"") begin
               phase_in     = PH_STR;
               tok_start_in = (pos_ff == POS_MAX) ? pos_ff : pos_ff + 1'b1;
               tok_len_in   = 16'd0;
            end else begin
               unique case (b)
                  "+": begin
                     res[n[0]] = mk(KIND_PLUS, p16, 16'd1, ERR_NONE, 8'd0, line_ff);
                     n = n + 2'd1;
                  end
                  "-": begin
                     res[n[0]] = mk(KIND_MINUS, p16, 16'd1, ERR_NONE, 8'd0, line_ff);
                     n = n + 2'd1;
                  end
                  "*": begin
                     res[n[0]] = mk(KIND_STAR, p16, 16'd1, ERR_NONE, 8'd0, line_ff);
                     n = n + 2'd1;
                  end
                  "/": begin
                     res[n[0]] = mk(KIND_SLASH, p16, 16'd1, ERR_NONE, 8'd0, line_ff);
                     n = n + 2'd1;
                  end
                  "%": begin
                     res[n[0]] = mk(KIND_PERCENT, p16, 16'd1, ERR_NONE, 8'd0, line_ff);
                     n = n + 2'd1;
                  end
                  "{": begin
                     res[n[0]] = mk(KIND_LBRACE, p16, 16'd1, ERR_NONE, 8'd0, line_ff);
                     n = n + 2'd1;
                  end
                  "}": begin
                     res[n[0]] = mk(KIND_RBRACE, p16, 16'd1, ERR_NONE, 8'd0, line_ff);
                     n = n + 2'd1;
                  end
                  "(": begin
                     res[n[0]] = mk(KIND_LPAREN, p16, 16'd1, ERR_NONE, 8'd0, line_ff);
                     n = n + 2'd1;
                  end
                  ")": begin
                     res[n[0]] = mk(KIND_RPAREN, p16, 16'd1, ERR_NONE, 8'd0, line_ff);
                     n = n + 2'd1;
                  end
                  "=": begin
                     phase_in     = PH_EQ;
                     tok_start_in = pos_ff;
                  end
                  "!": begin
                     phase_in     = PH_BANG;
                     tok_start_in = pos_ff;
                  end
                  "<": begin
                     phase_in     = PH_LT;
                     tok_start_in = pos_ff;
                  end
                  ">": begin
                     phase_in     = PH_GT;
                     tok_start_in = pos_ff;
                  end
                  ".": begin
                     phase_in     = PH_DOT;
                     tok_start_in = pos_ff;
                  end
                  default: begin
                     res[n[0]] = mk(KIND_ERROR, p16, 16'd1, ERR_UNKNOWN, b, line_ff);
                     n = n + 2'd1;
                     phase_in = PH_ERR;
                  end
               endcase
            end
         end

         pos_in = (pos_ff == POS_MAX) ? pos_ff : pos_ff + 1'b1;
      end

      // last flag on the final result of the transaction
      if (n == 2'd1) res[0].last_result = 1'b1;
      if (n == 2'd2) res[1].last_result = 1'b1;
   end

   assign push.count = n;
   assign push.slot0 = res[0];
   assign push.slot1 = res[1];

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_START;
         pos_ff       <= '0;
         line_ff      <= 16'd1;
         tok_start_ff <= '0;
         tok_len_ff   <= 16'd0;
         window_ff    <= '0;
      end else begin
         phase_ff     <= phase_in;
         pos_ff       <= pos_in;
         line_ff      <= line_in;
         tok_start_ff <= tok_start_in;
         tok_len_ff   <= tok_len_in;
         window_ff    <= window_in;
      end
   end

endmodule

// ===== sv/stt_queue.sv =====
module stt_queue import stt_pkg::*; (
   input  logic           clock,
   input  logic           reset,
   input  stt_push_type   push,
   output logic           room,
   output logic           out_valid,
   input  logic           out_ready,
   output stt_result_type out_data
);

   localparam int PTR_W = $clog2(QUEUE_DEPTH);
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
   localparam logic [CNT_W-1:0] ROOM_LIMIT = CNT_W'(QUEUE_DEPTH - 2);

   stt_result_type   entry_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0] head_ff, head_in;
   logic [PTR_W-1:0] tail_ff, tail_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             pop;

   // room for the two results a transaction may bring
   assign room      = count_ff <= ROOM_LIMIT;
   assign out_valid = count_ff != '0;
   assign out_data  = entry_ff[head_ff];
   assign pop       = out_valid && out_ready;

   always_comb begin
      head_in  = pop ? head_ff + PTR_W'(1) : head_ff;
      tail_in  = tail_ff + PTR_W'(push.count);
      count_in = count_ff + CNT_W'(push.count) - CNT_W'(pop);
   end

   always_ff @(posedge clock) begin
      if (push.count != 2'd0) entry_ff[tail_ff] <= push.slot0;
      if (push.count == 2'd2) entry_ff[tail_ff + PTR_W'(1)] <= push.slot1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff  <= '0;
         tail_ff  <= '0;
         count_ff <= '0;
      end else begin
         head_ff  <= head_in;
         tail_ff  <= tail_in;
         count_ff <= count_in;
      end
   end

`ifndef NO_ASSERTIONS
   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      (push.count != 2'd0) |-> room)
      else $error("results pushed without room");

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(QUEUE_DEPTH))
      else $error("queue count above depth");

   a_pop_only: assert property (@(posedge clock) disable iff (reset)
      (pop && push.count == 2'd0) |=> count_ff == $past(count_ff) - CNT_W'(1))
      else $error("count not decremented on pop");

   a_ptr_gap: assert property (@(posedge clock) disable iff (reset)
      (count_ff != CNT_W'(QUEUE_DEPTH)) |->
         (tail_ff - head_ff) == PTR_W'(count_ff))
      else $error("pointers disagree with count");
`endif

endmodule

// ===== sv/source_text_tokenizer.sv =====
// Streaming lexer: takes source text one byte per transaction on req_bus and
// an end transaction to close the text, and gives one rsp_bus transaction per
// token (kind, text offset and length, line, error code and byte, last flag).
// A byte is taken every cycle while the four-entry result queue has room for
// two results; results leave it one per cycle while rsp_bus is ready, and are
// queued as the byte that closes the token is taken. Lookahead is one pending
// character, held in the scan phase, so one byte can close one token and emit
// another. A stalled rsp_bus fills the queue and then holds req_bus off.
module source_text_tokenizer import stt_pkg::*; #(
   parameter int POSITION_BITS = POSITION_BITS_DEFAULT
) (
   input logic        clock,
   input logic        reset,
   stt_req_if.sink    req_bus,
   stt_rsp_if.source  rsp_bus
);

   stt_push_type push;
   logic         room;
   logic         accept;

   assign req_bus.ready = room;
   assign accept        = req_bus.valid && room;

   stt_lexer #(
      .POSITION_BITS (POSITION_BITS)
   ) u_lexer (
      .clock  (clock),
      .reset  (reset),
      .accept (accept),
      .item   (req_bus.data),
      .push   (push)
   );

   stt_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .room      (room),
      .out_valid (rsp_bus.valid),
      .out_ready (rsp_bus.ready),
      .out_data  (rsp_bus.data)
   );

endmodule

// ===== test/token_stream_check.sv =====
module token_stream_check import stt_pkg::*; (
   input  logic clock,
   input  logic reset,
   stt_req_if   req_bus,
   stt_rsp_if   rsp_bus,
   output int   mismatch_count,
   output int   tokens_waiting,
   output int   tokens_checked
);

   typedef enum logic [3:0] {
      LEX_START,
      LEX_IDENT,
      LEX_NUMBER,
      LEX_STRING,
      LEX_EQ,
      LEX_BANG,
      LEX_LT,
      LEX_GT,
      LEX_DOT,
      LEX_SKIP
   } lex_phase_type;

   // keyword spellings, first character in the low byte, in kind order
   localparam logic [39:0] KEYWORD_SPELLING [8] = '{
      40'h00_7473_656e, 40'h00_0074_656c, 40'h00_0000_6669, 40'h00_6573_6c65,
      40'h65_6c69_6877, 40'h00_0072_6f66, 40'h00_0000_6e69, 40'h74_6e69_7270
   };
   localparam int KEYWORD_CHARS [8] = '{4, 3, 2, 4, 5, 3, 2, 5};

   lex_phase_type  phase;
   logic [15:0]    position;
   logic [15:0]    line_no;
   logic [15:0]    tok_start;
   logic [15:0]    tok_len;
   logic [39:0]    word_window;
   int             item_tokens;
   stt_result_type expected_tokens [$];

   function automatic logic [15:0] bump(logic [15:0] v);
      return (v == 16'hffff) ? v : v + 16'd1;
   endfunction

   function automatic logic is_digit(logic [7:0] b);
      return b >= "0" && b <= "9";
   endfunction

   function automatic logic is_letter(logic [7:0] b);
      return (b >= "a" && b <= "z") || (b >= "A" && b <= "Z");
   endfunction

   function automatic logic is_space(logic [7:0] b);
      return b == " " || (b >= 8'h09 && b <= 8'h0d);
   endfunction

   function automatic void clear_state();
      phase       = LEX_START;
      position    = 16'd0;
      line_no     = 16'd1;
      tok_start   = 16'd0;
      tok_len     = 16'd0;
      word_window = 40'd0;
   endfunction

   function automatic void push_token(logic [4:0] kind, logic [15:0] start, logic [15:0] len,
                                      logic [1:0] err, logic [7:0] err_byte);
      stt_result_type t;
      t.token_kind      = kind;
      t.text_start      = start;
      t.text_length     = len;
      t.line_number_out = line_no;
      t.error_kind      = err;
      t.error_byte      = err_byte;
      t.last_result     = 1'b0;
      expected_tokens = {expected_tokens, t};
      item_tokens++;
   endfunction

   function automatic logic [4:0] word_kind();
      logic [4:0] kind;
      kind = KIND_IDENT;
      for (int k = 0; k < 8; k++)
         if (tok_len == 16'(KEYWORD_CHARS[k]) && word_window == KEYWORD_SPELLING[k])
            kind = KIND_KW_BASE + 5'(k);
      return kind;
   endfunction

   // token that the current phase holds open, as it stands when cut short
   function automatic void close_open_token();
      case (phase)
         LEX_IDENT:  push_token(word_kind(), tok_start, tok_len, ERR_NONE, 8'd0);
         LEX_NUMBER: push_token(KIND_NUMBER, tok_start, tok_len, ERR_NONE, 8'd0);
         LEX_STRING: push_token(KIND_STRING, tok_start, tok_len, ERR_NONE, 8'd0);
         LEX_EQ:     push_token(KIND_ASSIGN, tok_start, 16'd1, ERR_NONE, 8'd0);
         LEX_LT:     push_token(KIND_LT, tok_start, 16'd1, ERR_NONE, 8'd0);
         LEX_GT:     push_token(KIND_GT, tok_start, 16'd1, ERR_NONE, 8'd0);
         LEX_BANG:   push_token(KIND_ERROR, tok_start, 16'd1, ERR_BANG, "!");
         LEX_DOT:    push_token(KIND_ERROR, tok_start, 16'd1, ERR_DOT, ".");
         default: ;
      endcase
   endfunction

   function automatic void begin_token(logic [7:0] b);
      phase = LEX_START;
      if (is_space(b)) begin
         if (b == 8'h0a)
            line_no = bump(line_no);
      end else if (is_digit(b)) begin
         phase     = LEX_NUMBER;
         tok_start = position;
         tok_len   = 16'd1;
      end else if (is_letter(b)) begin
         phase       = LEX_IDENT;
         tok_start   = position;
         tok_len     = 16'd1;
         word_window = {32'd0, b};
      end else begin
         case (b)
            "\"": begin
               phase     = LEX_STRING;
               tok_start = bump(position);
               tok_len   = 16'd0;
            end
            "+": push_token(KIND_PLUS, position, 16'd1, ERR_NONE, 8'd0);
            "-": push_token(KIND_MINUS, position, 16'd1, ERR_NONE, 8'd0);
            "*": push_token(KIND_STAR, position, 16'd1, ERR_NONE, 8'd0);
            "/": push_token(KIND_SLASH, position, 16'd1, ERR_NONE, 8'd0);
            "%": push_token(KIND_PERCENT, position, 16'd1, ERR_NONE, 8'd0);
            "{": push_token(KIND_LBRACE, position, 16'd1, ERR_NONE, 8'd0);
            "}": push_token(KIND_RBRACE, position, 16'd1, ERR_NONE, 8'd0);
            "(": push_token(KIND_LPAREN, position, 16'd1, ERR_NONE, 8'd0);
            ")": push_token(KIND_RPAREN, position, 16'd1, ERR_NONE, 8'd0);
            "=": begin
               phase     = LEX_EQ;
               tok_start = position;
            end
            "!": begin
               phase     = LEX_BANG;
               tok_start = position;
            end
            "<": begin
               phase     = LEX_LT;
               tok_start = position;
            end
            ">": begin
               phase     = LEX_GT;
               tok_start = position;
            end
            ".": begin
               phase     = LEX_DOT;
               tok_start = position;
            end
            default: begin
               push_token(KIND_ERROR, position, 16'd1, ERR_UNKNOWN, b);
               phase = LEX_SKIP;
            end
         endcase
      end
   endfunction

   function automatic void predict_item(stt_item_type item);
      stt_result_type tail;
      logic [7:0]     b;
      logic [4:0]     pair_kind;
      b           = item.source_byte;
      item_tokens = 0;
      if (item.end_of_source) begin
         close_open_token();
         push_token(KIND_END, position, 16'd0, ERR_NONE, 8'd0);
         clear_state();
      end else begin
         case (phase)
            LEX_IDENT: begin
               if (is_letter(b) || is_digit(b) || b == "_") begin
                  if (tok_len < 16'd5)
                     word_window[8*tok_len +: 8] = b;
                  tok_len = bump(tok_len);
               end else begin
                  close_open_token();
                  begin_token(b);
               end
            end
            LEX_NUMBER: begin
               if (is_digit(b)) begin
                  tok_len = bump(tok_len);
               end else begin
                  close_open_token();
                  begin_token(b);
               end
            end
            LEX_STRING: begin
               if (b == "\"") begin
                  close_open_token();
                  phase = LEX_START;
               end else begin
                  tok_len = bump(tok_len);
               end
            end
            LEX_EQ, LEX_LT, LEX_GT: begin
               if (b == "=") begin
                  pair_kind = (phase == LEX_EQ) ? KIND_EQ : (phase == LEX_LT) ? KIND_LTE : KIND_GTE;
                  push_token(pair_kind, tok_start, 16'd2, ERR_NONE, 8'd0);
                  phase = LEX_START;
               end else begin
                  close_open_token();
                  begin_token(b);
               end
            end
            LEX_BANG, LEX_DOT: begin
               if (phase == LEX_BANG && b == "=") begin
                  push_token(KIND_NEQ, tok_start, 16'd2, ERR_NONE, 8'd0);
                  phase = LEX_START;
               end else if (phase == LEX_DOT && b == ".") begin
                  push_token(KIND_DOTDOT, tok_start, 16'd2, ERR_NONE, 8'd0);
                  phase = LEX_START;
               end else begin
                  close_open_token();
                  phase = LEX_SKIP;
               end
            end
            LEX_SKIP: ;
            default: begin_token(b);
         endcase
         position = bump(position);
      end
      if (item_tokens > 0) begin
         tail = expected_tokens[$];
         tail.last_result = 1'b1;
         expected_tokens[expected_tokens.size() - 1] = tail;
      end
   endfunction

   function automatic string token_text(stt_result_type t);
      return $sformatf("kind %0d start %0d len %0d line %0d err %0d byte %02h last %0d",
                       t.token_kind, t.text_start, t.text_length, t.line_number_out,
                       t.error_kind, t.error_byte, t.last_result);
   endfunction

   always @(posedge clock) begin
      stt_result_type got;
      stt_result_type want;
      logic           bad;
      if (reset) begin
         clear_state();
         expected_tokens.delete();
         mismatch_count <= 0;
         tokens_checked <= 0;
      end else begin
         if (req_bus.valid && req_bus.ready)
            predict_item(req_bus.data);
         if (rsp_bus.valid && rsp_bus.ready) begin
            got = rsp_bus.data;
            bad = 1'b0;
            if (expected_tokens.size() == 0) begin
               bad = 1'b1;
               if (mismatch_count < 10)
                  $display("unexpected token: %s", token_text(got));
            end else begin
               want = expected_tokens.pop_front();
               bad = (got.token_kind !== want.token_kind) ||
                     (got.text_start !== want.text_start) ||
                     (got.text_length !== want.text_length) ||
                     (got.line_number_out !== want.line_number_out) ||
                     (got.error_kind !== want.error_kind) ||
                     (got.error_byte !== want.error_byte) ||
                     (got.last_result !== want.last_result);
               if (bad && mismatch_count < 10)
                  $display("token mismatch: expected %s, got %s",
                           token_text(want), token_text(got));
            end
            if (bad)
               mismatch_count <= mismatch_count + 1;
            tokens_checked <= tokens_checked + 1;
         end
      end
      tokens_waiting <= expected_tokens.size();
   end

endmodule

// ===== test/testbench.sv =====
module testbench import stt_pkg::*;;

   localparam int QUIET_LIMIT = 4000;

   logic  clock = 1'b0;
   logic  reset;
   int    send_gap_pct;
   int    recv_stall_pct;
   int    items_sent;
   int    texts_sent;
   int    quiet_cycles;
   int    mismatch_count;
   int    tokens_waiting;
   int    tokens_checked;
   string operator_text [17] = '{"+", "-", "*", "/", "%", "{", "}", "(", ")",
                                 "=", "==", "<", "<=", ">", ">=", "!=", ".."};

   stt_req_if req_bus ();
   stt_rsp_if rsp_bus ();

   source_text_tokenizer u_dut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus)
   );

   token_stream_check u_token_check (
      .clock          (clock),
      .reset          (reset),
      .req_bus        (req_bus),
      .rsp_bus        (rsp_bus),
      .mismatch_count (mismatch_count),
      .tokens_waiting (tokens_waiting),
      .tokens_checked (tokens_checked)
   );

   always #2 clock = ~clock;

   always @(posedge clock)
      rsp_bus.ready <= ($urandom_range(0, 99) >= recv_stall_pct);

   // no transaction on either side for too long means a hang
   always @(posedge clock) begin
      if (reset || (req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= QUIET_LIMIT) begin
         $display("watchdog: no transaction for %0d cycles", QUIET_LIMIT);
         $display("TEST FAILED");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   task automatic send_item(logic [7:0] b, logic eos);
      while ($urandom_range(0, 99) < send_gap_pct) begin
         req_bus.valid <= 1'b0;
         @(posedge clock);
      end
      req_bus.valid <= 1'b1;
      req_bus.data  <= '{source_byte: b, end_of_source: eos};
      do
         @(posedge clock);
      while (!req_bus.ready);
      items_sent++;
      if (eos)
         texts_sent++;
   endtask

   task automatic send_chars(string s);
      for (int i = 0; i < s.len(); i++)
         send_item(s[i], 1'b0);
   endtask

   task automatic end_text();
      send_item(8'($urandom_range(0, 255)), 1'b1);
   endtask

   function automatic logic [7:0] word_char();
      int r;
      r = $urandom_range(0, 62);
      if (r < 26)
         return 8'("a" + r);
      else if (r < 52)
         return 8'("A" + r - 26);
      else if (r < 62)
         return 8'("0" + r - 52);
      return "_";
   endfunction

   function automatic logic [7:0] string_char();
      logic [7:0] c;
      do
         c = 8'($urandom_range(0, 255));
      while (c == "\"");
      return c;
   endfunction

   function automatic logic [7:0] space_char();
      return ($urandom_range(0, 2) == 0) ? " " : 8'($urandom_range(9, 13));
   endfunction

   // one text of random tokens; a bang, a dot or a random byte ends it, followed by up to three random bytes
   task automatic send_random_text();
      int tokens;
      int pick;
      int k;
      bit broken;
      tokens = $urandom_range(0, 12);
      broken = 1'b0;
      for (int t = 0; t < tokens && !broken; t++) begin
         pick = $urandom_range(0, 99);
         if (pick < 15) begin
            k = $urandom_range(0, 7);
            for (int i = 0; i < KW_LEN[k]; i++)
               send_item(KW_TEXT[k][8*i +: 8], 1'b0);
            if ($urandom_range(0, 3) == 0)
               send_item(word_char(), 1'b0);
         end else if (pick < 30) begin
            send_item(($urandom_range(0, 1) == 0) ? 8'("a" + $urandom_range(0, 25)) :
                                                     8'("A" + $urandom_range(0, 25)), 1'b0);
            repeat ($urandom_range(0, 9))
               send_item(word_char(), 1'b0);
         end else if (pick < 42) begin
            repeat ($urandom_range(1, 6))
               send_item(8'("0" + $urandom_range(0, 9)), 1'b0);
         end else if (pick < 52) begin
            send_item("\"", 1'b0);
            repeat ($urandom_range(0, 8))
               send_item(($urandom_range(0, 3) == 0) ? 8'h0a : string_char(), 1'b0);
            if ($urandom_range(0, 9) != 0)
               send_item("\"", 1'b0);
         end else if (pick < 70) begin
            repeat ($urandom_range(1, 3))
               send_item(space_char(), 1'b0);
         end else if (pick < 93) begin
            send_chars(operator_text[$urandom_range(0, 16)]);
         end else if (pick < 96) begin
            send_item(($urandom_range(0, 1) == 0) ? "!" : ".", 1'b0);
            broken = 1'b1;
         end else begin
            send_item(8'($urandom_range(0, 255)), 1'b0);
            broken = 1'b1;
         end
         if (!broken && $urandom_range(0, 1) == 0)
            send_item(space_char(), 1'b0);
      end
      if (broken)
         repeat ($urandom_range(0, 3))
            send_item(8'($urandom_range(0, 255)), 1'b0);
      end_text();
   endtask

   task automatic send_random_texts(int item_goal);
      int goal;
      goal = items_sent + item_goal;
      while (items_sent < goal)
         send_random_text();
   endtask

   initial begin
      req_bus.valid  <= 1'b0;
      req_bus.data   <= '0;
      reset          <= 1'b1;
      send_gap_pct   = 27;
      recv_stall_pct = 47;
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // keyword, two-char compare, number into word, open string at end
      send_chars("print>=9a\"\n");
      end_text();
      send_chars("_");
      end_text();
      send_chars("!");
      end_text();
      send_chars(".");
      send_item(8'hff, 1'b0);
      end_text();
      send_chars("<");
      end_text();
      send_item(8'h00, 1'b0);
      end_text();

      send_random_texts(300);
      send_gap_pct   = 47;
      recv_stall_pct = 27;
      send_random_texts(310);
      send_gap_pct   = 0;
      recv_stall_pct = 0;
      send_random_texts(310);
      req_bus.valid <= 1'b0;

      @(posedge clock);
      wait (tokens_waiting == 0);
      repeat (10) @(posedge clock);

      $display("sent %0d transactions in %0d texts, checked %0d tokens",
               items_sent, texts_sent, tokens_checked);
      $display("covered keywords, words, numbers, strings, operators and errors"
               , " under three idle mixes");
      if (mismatch_count == 0 && tokens_waiting == 0)
         $display("TEST PASSED");
      else
         $display("TEST FAILED");
      $finish;
   end

endmodule

// ===== files.f =====
sv/stt_pkg.sv
sv/stt_req_if.sv
sv/stt_rsp_if.sv
sv/stt_lexer.sv
sv/stt_queue.sv
sv/source_text_tokenizer.sv
test/token_stream_check.sv
test/testbench.sv
